// File: design/psft_pkg.sv
// Shared types and constants for the pulse slot frame transmitter.
`default_nettype none

package psft_pkg;

   localparam int BYTE_W            = 8;
   localparam int IDX_W             = 3;
   localparam int REQ_W             = 2;
   localparam int HEAD_BIT          = 7;
   localparam int FRAME_BYTES_DEF   = 8;
   localparam int PREAMBLE_BITS_DEF = 8;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_TICK  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_LOW   = 2'd1,
      PH_ZERO  = 2'd2
   } phase_type;

   // Commands from the controller to every cell of the byte chain.
   typedef struct packed {
      logic              load;
      logic [IDX_W-1:0]  load_index;
      logic [BYTE_W-1:0] load_byte;
      logic              shift;
      logic              set_head;
   } cell_ctrl_type;

   typedef struct packed {
      logic tx_level;
      logic tx_empty;
      logic busy_res;
   } rsp_type;

endpackage

`default_nettype wire

// File: design/psft_cell.sv
// One byte cell of the frame shift chain.
`default_nettype none

module psft_cell
   import psft_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter bit IS_HEAD    = 1'b0
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          shift_in,
   output logic               msb_out
);

   localparam bit               IDX_OK = (CELL_INDEX < (1 << IDX_W));
   localparam logic [IDX_W-1:0] CELL_ID = IDX_W'(CELL_INDEX);

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.load && IDX_OK && (ctrl.load_index == CELL_ID)) begin
         byte_in = ctrl.load_byte;
      end else if (ctrl.shift) begin
         byte_in = {byte_ff[BYTE_W-2:0], shift_in};
      end else if (ctrl.set_head && IS_HEAD) begin
         byte_in = byte_ff;
         byte_in[HEAD_BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign msb_out = byte_ff[HEAD_BIT];

endmodule

`default_nettype wire

// File: design/psft_ctrl.sv
// Slot sequencer: bit counter, half slot phase and pin level decisions.
`default_nettype none

module psft_ctrl
   import psft_pkg::*;
#(
   parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
   parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [REQ_W-1:0]  req_type,
   input  wire logic [IDX_W-1:0]  byte_index,
   input  wire logic [BYTE_W-1:0] byte_value,
   input  wire logic              head_bit,
   output cell_ctrl_type          cell_ctrl,
   output rsp_type                rsp
);

   localparam int FRAME_BITS = FRAME_BYTES * BYTE_W;
   localparam int TOTAL_BITS = FRAME_BITS + PREAMBLE_BITS;
   localparam int CNT_W      = $clog2(TOTAL_BITS + 1);

   localparam logic [CNT_W-1:0] TOTAL_CNT = CNT_W'(TOTAL_BITS);
   localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   logic [CNT_W-1:0] bits_ff;
   logic [CNT_W-1:0] bits_in;
   phase_type        phase_ff;
   phase_type        phase_in;

   logic is_tick;
   logic preamble;

   assign is_tick  = accept && (req_code_type'(req_type) == REQ_TICK) && (bits_ff != '0);
   assign preamble = bits_ff > FRAME_CNT;

   // Next state.
   always_comb begin
      bits_in  = bits_ff;
      phase_in = phase_ff;
      if (accept && (req_code_type'(req_type) == REQ_START)) begin
         bits_in  = TOTAL_CNT;
         phase_in = PH_START;
      end else if (is_tick) begin
         case (phase_ff)
            PH_LOW: begin
               bits_in  = bits_ff - ONE_CNT;
               phase_in = PH_START;
            end
            PH_ZERO: begin
               phase_in = PH_START;
            end
            default: begin
               phase_in = (preamble || head_bit) ? PH_LOW : PH_ZERO;
            end
         endcase
      end
   end

   // Outputs to the cell chain and the result.
   always_comb begin
      cell_ctrl            = '0;
      cell_ctrl.load       = accept && (req_code_type'(req_type) == REQ_LOAD);
      cell_ctrl.load_index = byte_index;
      cell_ctrl.load_byte  = byte_value;
      rsp                  = '0;
      if (is_tick) begin
         case (phase_ff)
            PH_LOW: begin
               cell_ctrl.shift = !preamble;
               rsp.tx_empty    = (bits_ff == ONE_CNT);
            end
            PH_ZERO: begin
               cell_ctrl.set_head = 1'b1;
            end
            default: begin
               rsp.tx_level = preamble || head_bit;
            end
         endcase
      end
      rsp.busy_res = (bits_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         phase_ff <= PH_START;
      end else begin
         bits_ff  <= bits_in;
         phase_ff <= phase_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= TOTAL_CNT)
      else $error("bit counter above the frame length");

   a_phase_needs_bits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_START) |-> (bits_ff != '0))
      else $error("slot phase open with no bits left");

   a_one_cell_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cell_ctrl.load, cell_ctrl.shift, cell_ctrl.set_head}))
      else $error("conflicting cell chain commands");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp.tx_empty |=> (bits_ff == '0))
      else $error("empty reported with bits still pending");

endmodule

`default_nettype wire

// File: design/psft_rsp_buf.sv
// Two entry result buffer: output register plus skid register.
`default_nettype none

module psft_rsp_buf
   import psft_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         out_valid,
   input  wire logic    out_stall,
   output rsp_type      out_data
);

   logic    out_v_ff;
   logic    out_v_in;
   logic    skid_v_ff;
   logic    skid_v_in;
   rsp_type out_ff;
   rsp_type out_in;
   rsp_type skid_ff;
   rsp_type skid_in;
   logic    pop;

   assign pop = out_v_ff && !out_stall;

   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      out_in    = out_ff;
      skid_in   = skid_ff;
      if (skid_v_ff) begin
         // Full: no push can arrive, a pop moves the skid entry forward.
         if (pop) begin
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end
      end else if (!out_v_ff || pop) begin
         out_v_in = push;
         out_in   = push_data;
      end else if (push) begin
         skid_v_in = 1'b1;
         skid_in   = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_v_ff;
   assign out_valid = out_v_ff;
   assign out_data  = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without an output entry");

endmodule

`default_nettype wire

// File: design/pulse_slot_frame_transmitter.sv
// Top level: pulse slot frame transmitter with a chain of byte cells.
// A result enters the output register, or the skid register while rsp_stall holds the output.
// Throughput: one request per cycle while req_stall is low; the controller and every cell update together.
// Up to two results are buffered; req_stall rises only when both slots hold results.
// Reset clears the frame cells to zero, the bit counter, the slot phase and the buffer valid flags.
`default_nettype none

module pulse_slot_frame_transmitter
   import psft_pkg::*;
#(
   parameter int FRAME_BYTES   = FRAME_BYTES_DEF,
   parameter int PREAMBLE_BITS = PREAMBLE_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [REQ_W-1:0]  req_type,
   input  wire logic [IDX_W-1:0]  req_byte_index,
   input  wire logic [BYTE_W-1:0] req_byte_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_tx_level,
   output logic                   rsp_tx_empty,
   output logic                   rsp_busy_res
);

   logic               accept;
   logic               full;
   cell_ctrl_type      cell_ctrl;
   rsp_type            rsp_new;
   rsp_type            rsp_out;
   logic [FRAME_BYTES:0] carry;

   assign accept    = req_valid && !full;
   assign req_stall = full;
   assign carry[0]  = 1'b0;

   psft_ctrl #(
      .FRAME_BYTES   (FRAME_BYTES),
      .PREAMBLE_BITS (PREAMBLE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req_type),
      .byte_index (req_byte_index),
      .byte_value (req_byte_value),
      .head_bit   (carry[FRAME_BYTES]),
      .cell_ctrl  (cell_ctrl),
      .rsp        (rsp_new)
   );

   // Cell i takes the top bit of cell i-1 on a shift; the last cell is the head.
   for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
      psft_cell #(
         .CELL_INDEX (i),
         .IS_HEAD    (i == FRAME_BYTES - 1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .shift_in (carry[i]),
         .msb_out  (carry[i+1])
      );
   end

   psft_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_new),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_out)
   );

   assign rsp_tx_level = rsp_out.tx_level;
   assign rsp_tx_empty = rsp_out.tx_empty;
   assign rsp_busy_res = rsp_out.busy_res;

endmodule

`default_nettype wire
